@@ hw/rtl/srmp_pkg.sv @@
// Shared types and constants for the serial response message parser.
// Used by srmp_core and serial_response_message_parser; no dependencies.

package srmp_pkg;

	localparam int StateW = 47;

	// One-hot parser states, named after the text matched so far.
	typedef enum logic [StateW-1:0] {
		ST_IDLE     = 47'd1 << 0,
		ST_LT       = 47'd1 << 1,
		ST_E        = 47'd1 << 2,
		ST_ER       = 47'd1 << 3,
		ST_ERR      = 47'd1 << 4,
		ST_O        = 47'd1 << 5,
		ST_OK       = 47'd1 << 6,
		ST_R        = 47'd1 << 7,
		ST_RC       = 47'd1 << 8,
		ST_RCO      = 47'd1 << 9,
		ST_RCOK     = 47'd1 << 10,
		ST_RT       = 47'd1 << 11,
		ST_RTC      = 47'd1 << 12,
		ST_RTCO     = 47'd1 << 13,
		ST_RTCOK    = 47'd1 << 14,
		ST_I        = 47'd1 << 15,
		ST_IC       = 47'd1 << 16,
		ST_IT       = 47'd1 << 17,
		ST_ITDATA   = 47'd1 << 18,
		ST_ITCR     = 47'd1 << 19,
		ST_B        = 47'd1 << 20,
		ST_BC       = 47'd1 << 21,
		ST_BCO      = 47'd1 << 22,
		ST_BCOK     = 47'd1 << 23,
		ST_S        = 47'd1 << 24,
		ST_SC       = 47'd1 << 25,
		ST_SCR      = 47'd1 << 26,
		ST_D        = 47'd1 << 27,
		ST_DS       = 47'd1 << 28,
		ST_DSC      = 47'd1 << 29,
		ST_DSO      = 47'd1 << 30,
		ST_DSOK     = 47'd1 << 31,
		ST_DSE      = 47'd1 << 32,
		ST_DSER     = 47'd1 << 33,
		ST_DSERR    = 47'd1 << 34,
		ST_DSB      = 47'd1 << 35,
		ST_DSBU     = 47'd1 << 36,
		ST_DSBUS    = 47'd1 << 37,
		ST_DSBUSY   = 47'd1 << 38,
		ST_DR       = 47'd1 << 39,
		ST_DRL      = 47'd1 << 40,
		ST_DRDATA   = 47'd1 << 41,
		ST_DRCR     = 47'd1 << 42,
		ST_U        = 47'd1 << 43,
		ST_UC       = 47'd1 << 44,
		ST_UCO      = 47'd1 << 45,
		ST_UCOK     = 47'd1 << 46
	} state_t;

	typedef enum logic [1:0] {
		PS_INCOMPLETE = 2'd0,
		PS_OK         = 2'd1,
		PS_BAD        = 2'd2,
		PS_IGNORED    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEC_TYPE    = 2'd0,
		SEC_VERSION = 2'd1,
		SEC_ID      = 2'd2,
		SEC_SPARE   = 2'd3
	} section_t;

	localparam logic [3:0] MT_ERROR        = 4'd0;
	localparam logic [3:0] MT_TEST         = 4'd1;
	localparam logic [3:0] MT_USB_RESET    = 4'd2;
	localparam logic [3:0] MT_MODULE_RESET = 4'd3;
	localparam logic [3:0] MT_USB_INFO     = 4'd4;
	localparam logic [3:0] MT_MODULE_INFO  = 4'd5;
	localparam logic [3:0] MT_USB_CONN     = 4'd6;
	localparam logic [3:0] MT_SPI_STATUS   = 4'd7;
	localparam logic [3:0] MT_DATA_SEND    = 4'd8;
	localparam logic [3:0] MT_ASYNC_DATA   = 4'd9;
	localparam logic [3:0] MT_SWITCH       = 4'd10;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef struct packed {
		status_t     status;
		logic [3:0]  msg_type;
		logic [15:0] position;
	} result_t;

endpackage

@@ hw/rtl/srmp_core.sv @@
// Parser state registers and next-state/result logic for one byte.
// Depends on srmp_pkg.

module srmp_core #(
	parameter logic [7:0] InfoBytes = 8'd8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_value,
	input  logic              first_byte,
	output srmp_pkg::result_t result
);

	srmp_pkg::state_t   state_q, cur_state, nxt_state;
	srmp_pkg::section_t sec_q, cur_sec, nxt_sec;
	logic [7:0]         left_q, cur_left, nxt_left;
	logic [7:0]         plen_q, cur_plen, nxt_plen;
	logic               decided_q, nxt_decided;
	logic [15:0]        pos_q, nxt_pos;
	logic [3:0]         type_q, nxt_type;
	srmp_pkg::status_t  status;
	logic               sec_id;
	logic [7:0]         b;

	assign b = byte_value;

	always_comb begin
		cur_state = first_byte ? srmp_pkg::ST_IDLE : state_q;
		cur_sec   = first_byte ? srmp_pkg::SEC_TYPE : sec_q;
		cur_left  = first_byte ? 8'd0 : left_q;
		cur_plen  = first_byte ? 8'd0 : plen_q;
		sec_id    = cur_sec[1];

		if (first_byte)
			nxt_pos = 16'd0;
		else if (pos_q != srmp_pkg::POS_MAX)
			nxt_pos = pos_q + 16'd1;
		else
			nxt_pos = pos_q;

		nxt_state   = cur_state;
		nxt_sec     = cur_sec;
		nxt_left    = cur_left;
		nxt_plen    = cur_plen;
		nxt_type    = type_q;
		nxt_decided = first_byte ? 1'b0 : decided_q;
		status      = srmp_pkg::PS_INCOMPLETE;

		if (nxt_decided) begin
			status = srmp_pkg::PS_IGNORED;
		end else begin
			unique case (cur_state)
				srmp_pkg::ST_IDLE:
					if (b == srmp_pkg::CH_LT) nxt_state = srmp_pkg::ST_LT;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_LT:
					if (b == "E") nxt_state = srmp_pkg::ST_E;
					else if (b == "O") nxt_state = srmp_pkg::ST_O;
					else if (b == "R") nxt_state = srmp_pkg::ST_R;
					else if (b == "I") nxt_state = srmp_pkg::ST_I;
					else if (b == "B") nxt_state = srmp_pkg::ST_B;
					else if (b == "S") nxt_state = srmp_pkg::ST_S;
					else if (b == "D") nxt_state = srmp_pkg::ST_D;
					else if (b == "U") nxt_state = srmp_pkg::ST_U;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_E:
					if (b == "R") nxt_state = srmp_pkg::ST_ER;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_ER:
					if (b == "R") nxt_state = srmp_pkg::ST_ERR;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_O:
					if (b == "K") nxt_state = srmp_pkg::ST_OK;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_R:
					if (b == "T") nxt_state = srmp_pkg::ST_RT;
					else if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_RC;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_RC:
					if (b == "O") nxt_state = srmp_pkg::ST_RCO;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_RCO:
					if (b == "K") nxt_state = srmp_pkg::ST_RCOK;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_RT:
					if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_RTC;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_RTC:
					if (b == "O") nxt_state = srmp_pkg::ST_RTCO;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_RTCO:
					if (b == "K") nxt_state = srmp_pkg::ST_RTCOK;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_I:
					if (b == "T") begin
						nxt_state = srmp_pkg::ST_IT;
					end else begin
						nxt_sec = srmp_pkg::SEC_TYPE;
						if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_IC;
						else status = srmp_pkg::PS_BAD;
					end
				srmp_pkg::ST_IC: begin
					// type#version#id; a code above id acts as id
					if (b == srmp_pkg::CH_CR && sec_id) begin
						nxt_type = srmp_pkg::MT_USB_INFO;
						status   = srmp_pkg::PS_OK;
					end else if (b == srmp_pkg::CH_HASH) begin
						if (sec_id)
							status = srmp_pkg::PS_BAD;
						else
							nxt_sec = srmp_pkg::section_t'(cur_sec + 2'd1);
					end else if (sec_id) begin
						if (!((b >= "0" && b <= "9") || (b >= "A" && b <= "H")))
							status = srmp_pkg::PS_BAD;
					end else if (cur_sec == srmp_pkg::SEC_VERSION) begin
						if (!((b >= "0" && b <= "9") || b == srmp_pkg::CH_DOT))
							status = srmp_pkg::PS_BAD;
					end
				end
				srmp_pkg::ST_IT: begin
					nxt_left = InfoBytes;
					if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_ITDATA;
					else status = srmp_pkg::PS_BAD;
				end
				srmp_pkg::ST_ITDATA:
					if (cur_left <= 8'd1) begin
						nxt_left  = 8'd0;
						nxt_state = srmp_pkg::ST_ITCR;
					end else begin
						nxt_left = cur_left - 8'd1;
					end
				srmp_pkg::ST_B:
					if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_BC;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_BC:
					if (b == "O") nxt_state = srmp_pkg::ST_BCO;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_BCO:
					if (b == "K") nxt_state = srmp_pkg::ST_BCOK;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_S:
					if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_SC;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_SC:
					nxt_state = srmp_pkg::ST_SCR;
				srmp_pkg::ST_D:
					if (b == "R") nxt_state = srmp_pkg::ST_DR;
					else if (b == "S") nxt_state = srmp_pkg::ST_DS;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DS:
					if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_DSC;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSC:
					if (b == "E") nxt_state = srmp_pkg::ST_DSE;
					else if (b == "B") nxt_state = srmp_pkg::ST_DSB;
					else if (b == "O") nxt_state = srmp_pkg::ST_DSO;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSO:
					if (b == "K") nxt_state = srmp_pkg::ST_DSOK;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSE:
					if (b == "R") nxt_state = srmp_pkg::ST_DSER;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSER:
					if (b == "R") nxt_state = srmp_pkg::ST_DSERR;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSB:
					if (b == "U") nxt_state = srmp_pkg::ST_DSBU;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSBU:
					if (b == "S") nxt_state = srmp_pkg::ST_DSBUS;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DSBUS:
					if (b == "Y") nxt_state = srmp_pkg::ST_DSBUSY;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_DR: begin
					nxt_plen  = b;
					nxt_state = srmp_pkg::ST_DRL;
				end
				srmp_pkg::ST_DRL:
					if (b != srmp_pkg::CH_COLON) begin
						status = srmp_pkg::PS_BAD;
					end else begin
						nxt_left  = cur_plen;
						// empty payload goes straight to the closing CR
						nxt_state = (cur_plen == 8'd0) ? srmp_pkg::ST_DRCR
						                               : srmp_pkg::ST_DRDATA;
					end
				srmp_pkg::ST_DRDATA:
					if (cur_left <= 8'd1) begin
						nxt_left  = 8'd0;
						nxt_state = srmp_pkg::ST_DRCR;
					end else begin
						nxt_left = cur_left - 8'd1;
					end
				srmp_pkg::ST_U:
					if (b == srmp_pkg::CH_COLON) nxt_state = srmp_pkg::ST_UC;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_UC:
					if (b == "O") nxt_state = srmp_pkg::ST_UCO;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_UCO:
					if (b == "K") nxt_state = srmp_pkg::ST_UCOK;
					else status = srmp_pkg::PS_BAD;
				srmp_pkg::ST_ERR, srmp_pkg::ST_OK, srmp_pkg::ST_RCOK, srmp_pkg::ST_RTCOK,
				srmp_pkg::ST_ITCR, srmp_pkg::ST_BCOK, srmp_pkg::ST_SCR, srmp_pkg::ST_DSOK,
				srmp_pkg::ST_DSERR, srmp_pkg::ST_DSBUSY, srmp_pkg::ST_DRCR,
				srmp_pkg::ST_UCOK: begin
					if (b == srmp_pkg::CH_CR) begin
						status = srmp_pkg::PS_OK;
						unique case (cur_state)
							srmp_pkg::ST_ERR:    nxt_type = srmp_pkg::MT_ERROR;
							srmp_pkg::ST_OK:     nxt_type = srmp_pkg::MT_TEST;
							srmp_pkg::ST_RCOK:   nxt_type = srmp_pkg::MT_USB_RESET;
							srmp_pkg::ST_RTCOK:  nxt_type = srmp_pkg::MT_MODULE_RESET;
							srmp_pkg::ST_ITCR:   nxt_type = srmp_pkg::MT_MODULE_INFO;
							srmp_pkg::ST_BCOK:   nxt_type = srmp_pkg::MT_USB_CONN;
							srmp_pkg::ST_SCR:    nxt_type = srmp_pkg::MT_SPI_STATUS;
							srmp_pkg::ST_DRCR:   nxt_type = srmp_pkg::MT_ASYNC_DATA;
							srmp_pkg::ST_UCOK:   nxt_type = srmp_pkg::MT_SWITCH;
							default:             nxt_type = srmp_pkg::MT_DATA_SEND;
						endcase
					end else begin
						status = srmp_pkg::PS_BAD;
					end
				end
				default:
					status = srmp_pkg::PS_BAD;
			endcase
			if (status == srmp_pkg::PS_OK || status == srmp_pkg::PS_BAD)
				nxt_decided = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srmp_pkg::ST_IDLE;
			sec_q     <= srmp_pkg::SEC_TYPE;
			left_q    <= 8'd0;
			plen_q    <= 8'd0;
			decided_q <= 1'b0;
			pos_q     <= 16'd0;
			type_q    <= srmp_pkg::MT_ERROR;
		end else if (step) begin
			state_q   <= nxt_state;
			sec_q     <= nxt_sec;
			left_q    <= nxt_left;
			plen_q    <= nxt_plen;
			decided_q <= nxt_decided;
			pos_q     <= nxt_pos;
			type_q    <= nxt_type;
		end
	end

	assign result.status   = status;
	assign result.msg_type = nxt_type;
	assign result.position = nxt_pos;

endmodule

@@ hw/rtl/serial_response_message_parser.sv @@
// Serial response message parser, top level: input beat register, parser core, result register.
// An accepted input beat is held in the input beat register; the core result for it is then
// held in the result register. Throughput: one byte per cycle unless m_tready stalls the
// result register. The input register and the result register each hold one beat, so one
// more beat is taken while a result waits. arst_n clears handshake state and parser state
// (initial state, position 0, last message type error). Depends on srmp_pkg and srmp_core.

module serial_response_message_parser #(
	parameter int MODULE_INFO_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tuser,   // [0] first_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] parse_status, [5:2] message_type,
	                               // [21:6] byte_position, [23:22] zero
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              first_s1;
	logic              out_valid_q;
	srmp_pkg::result_t out_q;
	srmp_pkg::result_t core_res;
	logic              advance;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
		if (advance && valid_s1)
			out_q <= core_res;
	end

	srmp_core #(
		.InfoBytes(8'(MODULE_INFO_BYTES))
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (valid_s1 && advance),
		.byte_value(byte_s1),
		.first_byte(first_s1),
		.result    (core_res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.position, out_q.msg_type, out_q.status};

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for serial_response_message_parser.
// A scoreboard class predicts parse status, last message type and byte position per byte;
// plain tasks drive byte beats and an initial block checks result beats. Depends on srmp_pkg and the RTL.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import srmp_pkg::*;

	localparam int INFO_LEN = 8;

	class response_checker;
		state_t      pstate;
		section_t    section;
		logic [7:0]  remaining;
		logic [7:0]  payload_len;
		bit          decided;
		logic [15:0] pos;
		logic [3:0]  last_type;
		result_t     expected_results[$];
		int          mismatch_count;

		function new();
			pstate = ST_IDLE;
			section = SEC_TYPE;
			remaining = '0;
			payload_len = '0;
			decided = 1'b0;
			pos = '0;
			last_type = MT_ERROR;
			mismatch_count = 0;
		endfunction

		function status_t match_char(logic [7:0] b, logic [7:0] c, state_t nxt);
			if (b != c)
				return PS_BAD;
			pstate = nxt;
			return PS_INCOMPLETE;
		endfunction

		function status_t end_message(logic [7:0] b, logic [3:0] kind);
			if (b != CH_CR)
				return PS_BAD;
			last_type = kind;
			return PS_OK;
		endfunction

		// type#version#id body of the info reply
		function status_t info_char(logic [7:0] b);
			section_t sec;
			sec = (section >= SEC_ID) ? SEC_ID : section;
			if (b == CH_CR && sec == SEC_ID) begin
				last_type = MT_USB_INFO;
				return PS_OK;
			end
			if (b == CH_HASH) begin
				if (sec == SEC_ID)
					return PS_BAD;
				section = section_t'(sec + 2'd1);
				return PS_INCOMPLETE;
			end
			if (sec == SEC_VERSION)
				return ((b >= "0" && b <= "9") || b == CH_DOT) ? PS_INCOMPLETE : PS_BAD;
			if (sec == SEC_ID)
				return ((b >= "0" && b <= "9") || (b >= "A" && b <= "H")) ?
					PS_INCOMPLETE : PS_BAD;
			return PS_INCOMPLETE;
		endfunction

		function status_t parse_next(logic [7:0] b);
			case (pstate)
				ST_IDLE:   return match_char(b, CH_LT, ST_LT);
				ST_LT: begin
					case (b)
						"E": pstate = ST_E;
						"O": pstate = ST_O;
						"R": pstate = ST_R;
						"I": pstate = ST_I;
						"B": pstate = ST_B;
						"S": pstate = ST_S;
						"D": pstate = ST_D;
						"U": pstate = ST_U;
						default: return PS_BAD;
					endcase
					return PS_INCOMPLETE;
				end
				ST_E:      return match_char(b, "R", ST_ER);
				ST_ER:     return match_char(b, "R", ST_ERR);
				ST_ERR:    return end_message(b, MT_ERROR);
				ST_O:      return match_char(b, "K", ST_OK);
				ST_OK:     return end_message(b, MT_TEST);
				ST_R: begin
					if (b == "T") begin
						pstate = ST_RT;
						return PS_INCOMPLETE;
					end
					return match_char(b, CH_COLON, ST_RC);
				end
				ST_RC:     return match_char(b, "O", ST_RCO);
				ST_RCO:    return match_char(b, "K", ST_RCOK);
				ST_RCOK:   return end_message(b, MT_USB_RESET);
				ST_RT:     return match_char(b, CH_COLON, ST_RTC);
				ST_RTC:    return match_char(b, "O", ST_RTCO);
				ST_RTCO:   return match_char(b, "K", ST_RTCOK);
				ST_RTCOK:  return end_message(b, MT_MODULE_RESET);
				ST_I: begin
					if (b == "T") begin
						pstate = ST_IT;
						return PS_INCOMPLETE;
					end
					section = SEC_TYPE;
					return match_char(b, CH_COLON, ST_IC);
				end
				ST_IC:     return info_char(b);
				ST_IT: begin
					remaining = 8'(INFO_LEN);
					return match_char(b, CH_COLON, ST_ITDATA);
				end
				ST_ITDATA: begin
					if (remaining <= 8'd1) begin
						remaining = '0;
						pstate = ST_ITCR;
					end else
						remaining = remaining - 8'd1;
					return PS_INCOMPLETE;
				end
				ST_ITCR:   return end_message(b, MT_MODULE_INFO);
				ST_B:      return match_char(b, CH_COLON, ST_BC);
				ST_BC:     return match_char(b, "O", ST_BCO);
				ST_BCO:    return match_char(b, "K", ST_BCOK);
				ST_BCOK:   return end_message(b, MT_USB_CONN);
				ST_S:      return match_char(b, CH_COLON, ST_SC);
				ST_SC: begin
					pstate = ST_SCR;
					return PS_INCOMPLETE;
				end
				ST_SCR:    return end_message(b, MT_SPI_STATUS);
				ST_D: begin
					if (b == "R") begin
						pstate = ST_DR;
						return PS_INCOMPLETE;
					end
					return match_char(b, "S", ST_DS);
				end
				ST_DS:     return match_char(b, CH_COLON, ST_DSC);
				ST_DSC: begin
					if (b == "E") begin
						pstate = ST_DSE;
						return PS_INCOMPLETE;
					end
					if (b == "B") begin
						pstate = ST_DSB;
						return PS_INCOMPLETE;
					end
					return match_char(b, "O", ST_DSO);
				end
				ST_DSO:    return match_char(b, "K", ST_DSOK);
				ST_DSOK:   return end_message(b, MT_DATA_SEND);
				ST_DSE:    return match_char(b, "R", ST_DSER);
				ST_DSER:   return match_char(b, "R", ST_DSERR);
				ST_DSERR:  return end_message(b, MT_DATA_SEND);
				ST_DSB:    return match_char(b, "U", ST_DSBU);
				ST_DSBU:   return match_char(b, "S", ST_DSBUS);
				ST_DSBUS:  return match_char(b, "Y", ST_DSBUSY);
				ST_DSBUSY: return end_message(b, MT_DATA_SEND);
				ST_DR: begin
					payload_len = b;
					pstate = ST_DRL;
					return PS_INCOMPLETE;
				end
				ST_DRL: begin
					if (b != CH_COLON)
						return PS_BAD;
					remaining = payload_len;
					// empty payload skips straight to the CR
					pstate = (payload_len == 8'd0) ? ST_DRCR : ST_DRDATA;
					return PS_INCOMPLETE;
				end
				ST_DRDATA: begin
					if (remaining <= 8'd1) begin
						remaining = '0;
						pstate = ST_DRCR;
					end else
						remaining = remaining - 8'd1;
					return PS_INCOMPLETE;
				end
				ST_DRCR:   return end_message(b, MT_ASYNC_DATA);
				ST_U:      return match_char(b, CH_COLON, ST_UC);
				ST_UC:     return match_char(b, "O", ST_UCO);
				ST_UCO:    return match_char(b, "K", ST_UCOK);
				ST_UCOK:   return end_message(b, MT_SWITCH);
				default:   return PS_BAD;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, bit first);
			result_t r;
			status_t s;
			if (first) begin
				pstate = ST_IDLE;
				section = SEC_TYPE;
				remaining = '0;
				payload_len = '0;
				decided = 1'b0;
				pos = '0;
			end else if (pos != POS_MAX)
				pos = pos + 16'd1;
			if (decided)
				s = PS_IGNORED;
			else begin
				s = parse_next(b);
				if (s == PS_OK || s == PS_BAD)
					decided = 1'b1;
			end
			r.status = s;
			r.msg_type = last_type;
			r.position = pos;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [23:0] word);
			result_t exp_r;
			if (expected_results.size() == 0) begin
				$error("result beat %h with no byte outstanding", word);
				mismatch_count++;
				return;
			end
			exp_r = expected_results.pop_front();
			if (word[1:0] != exp_r.status) begin
				$error("parse_status: expected %0d, actual %0d", exp_r.status, word[1:0]);
				mismatch_count++;
			end
			if (word[5:2] != exp_r.msg_type) begin
				$error("message_type: expected %0d, actual %0d", exp_r.msg_type, word[5:2]);
				mismatch_count++;
			end
			if (word[21:6] != exp_r.position) begin
				$error("byte_position: expected %0d, actual %0d", exp_r.position, word[21:6]);
				mismatch_count++;
			end
			if (word[23:22] != 2'b00) begin
				$error("pad bits: expected 0, actual %0d", word[23:22]);
				mismatch_count++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	response_checker sb = new();

	logic [7:0] msg_bytes[$];
	bit         msg_first[$];
	bit         steady;
	bit         hold_request;
	int         hold_left;
	int         bytes_sent;

	string keyword_forms[9] = '{"<ERR", "<OK", "<R:OK", "<RT:OK", "<B:OK", "<U:OK",
		"<DS:OK", "<DS:ERR", "<DS:BUSY"};
	string version_chars = "0123456789.";
	string id_chars = "0123456789ABCDEFGH";

	serial_response_message_parser #(
		.MODULE_INFO_BYTES(INFO_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit first);
		int idle;
		idle = 0;
		if (!steady && hold_left == 0 && $urandom_range(0, 99) < 40)
			idle = gap_len();
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_byte(b, first);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg_bytes.push_back(s[i]);
	endtask

	task automatic set_flags(input bit head);
		msg_first.delete();
		foreach (msg_bytes[i])
			msg_first.push_back(1'b0);
		msg_first[0] = head;
	endtask

	task automatic play();
		foreach (msg_bytes[i]) begin
			send_byte(msg_bytes[i], msg_first[i]);
			bytes_sent++;
		end
	endtask

	// one response, mostly well formed, sometimes damaged or followed by junk
	task automatic build_message();
		int kind;
		int n;
		int r;
		logic [7:0] b;
		logic [7:0] len;
		msg_bytes.delete();
		kind = $urandom_range(0, 15);
		if (kind < 5) begin
			add_text(keyword_forms[$urandom_range(0, 8)]);
			msg_bytes.push_back(CH_CR);
		end else if (kind == 5) begin
			add_text("<S:");
			msg_bytes.push_back(8'($urandom));
			msg_bytes.push_back(CH_CR);
		end else if (kind < 8) begin
			add_text("<I:");
			n = $urandom_range(0, 3);
			repeat (n) begin
				b = 8'($urandom);
				// a hash would end the type field early; use a CR type byte instead
				msg_bytes.push_back(b == CH_HASH ? CH_CR : b);
			end
			msg_bytes.push_back(CH_HASH);
			n = $urandom_range(0, 4);
			repeat (n)
				msg_bytes.push_back(version_chars[$urandom_range(0, version_chars.len() - 1)]);
			msg_bytes.push_back(CH_HASH);
			n = $urandom_range(0, 3);
			repeat (n)
				msg_bytes.push_back(id_chars[$urandom_range(0, id_chars.len() - 1)]);
			msg_bytes.push_back(CH_CR);
		end else if (kind == 8) begin
			add_text("<IT:");
			repeat (INFO_LEN)
				msg_bytes.push_back(8'($urandom));
			msg_bytes.push_back(CH_CR);
		end else if (kind < 12) begin
			add_text("<DR");
			if ($urandom_range(0, 99) < 95)
				len = 8'($urandom_range(0, 6));
			else
				len = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'($urandom_range(7, 254));
			msg_bytes.push_back(len);
			msg_bytes.push_back(CH_COLON);
			repeat (len)
				msg_bytes.push_back(8'($urandom));
			msg_bytes.push_back(CH_CR);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n)
				msg_bytes.push_back(8'($urandom));
			if ($urandom_range(0, 1) != 0)
				msg_bytes[0] = CH_LT;
		end
		r = $urandom_range(0, 99);
		if (r < 15 && msg_bytes.size() > 1)
			msg_bytes[$urandom_range(1, msg_bytes.size() - 1)] = 8'($urandom);
		else if (r < 25 && msg_bytes.size() > 1) begin
			n = $urandom_range(1, msg_bytes.size() - 1);
			while (msg_bytes.size() > n)
				void'(msg_bytes.pop_back());
		end else if (r < 40) begin
			n = $urandom_range(1, 3);
			repeat (n)
				msg_bytes.push_back(8'($urandom));
		end
		set_flags($urandom_range(0, 99) < 96);
		if ($urandom_range(0, 99) < 3)
			msg_first[$urandom_range(0, msg_first.size() - 1)] = 1'b1;
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 250;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 35) begin
				hold_left = gap_len() - 1;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int msg_count;
		int w;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		hold_request = 1'b0;
		bytes_sent = 0;
		msg_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first message after reset arrives without a first-byte mark
		msg_bytes.delete();
		add_text("<OK");
		msg_bytes.push_back(CH_CR);
		msg_bytes.push_back("X");
		set_flags(1'b0);
		play();
		// async data with empty payload
		msg_bytes.delete();
		add_text("<DR");
		msg_bytes.push_back(8'h00);
		msg_bytes.push_back(CH_COLON);
		msg_bytes.push_back(CH_CR);
		set_flags(1'b1);
		play();
		// CR as a type byte, then a hash inside the id field
		msg_bytes.delete();
		add_text("<I:");
		msg_bytes.push_back(CH_CR);
		add_text("#1.#A#Z");
		set_flags(1'b1);
		play();
		// CR inside the version field
		msg_bytes.delete();
		add_text("<I:#");
		msg_bytes.push_back(CH_CR);
		set_flags(1'b1);
		play();

		bytes_sent = 0;
		while (bytes_sent < 750) begin
			build_message();
			msg_count++;
			if (msg_count == 30)
				hold_request = 1'b1;
			else if (hold_left == 0)
				steady = ($urandom_range(0, 99) < 15);
			play();
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		for (w = 0; w < 100000 && sb.expected_results.size() != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.expected_results.size() != 0) begin
			$error("%0d results never arrived", sb.expected_results.size());
			sb.mismatch_count++;
		end
		if (sb.mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/srmp_pkg.sv
hw/rtl/srmp_core.sv
hw/rtl/serial_response_message_parser.sv
tb/sv/testbench.sv
